[rtl/core/ursq_pkg.sv]
// Shared types, codes and constants for the ultrasonic range sequencer.
// No dependencies; imported by every module of the block.
package ursq_pkg;

    localparam int unsigned INTERVAL_W  = 20;
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned DIST_W      = 14;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 20;

    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = '1;

    // Trigger pulse: low for two ticks, then high for ten ticks.
    localparam logic [COUNT_W:0] LOW_TICKS  = 17'd2;
    localparam logic [COUNT_W:0] HIGH_TICKS = 17'd10;

    // Distance is width * 343 / 2000, done as width * ceil(343 * 2^28 / 2000) >> 28.
    // The rounding error stays below 1/2000 over the whole 16-bit width range.
    localparam int unsigned     DIST_SHIFT = 28;
    localparam logic [25:0]     DIST_MULT  = 26'd46036681;
    localparam int unsigned     PROD_W     = COUNT_W + 26;

    // Register reset values.
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 20'd60000;
    localparam logic [COUNT_W-1:0]    RISE_TO_RST  = 16'd3000;
    localparam logic [COUNT_W-1:0]    ECHO_TO_RST  = 16'd30000;
    localparam logic [15:0]           NEAR_RST     = 16'd300;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_INTERVAL = 2'd0,
        CFG_RISE_TO  = 2'd1,
        CFG_ECHO_TO  = 2'd2,
        CFG_NEAR     = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TRIG_LOW  = 3'd1,
        PH_TRIG_HIGH = 3'd2,
        PH_WAIT_RISE = 3'd3,
        PH_MEASURE   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_WAIT    = 2'd1,
        ST_READY   = 2'd2,
        ST_TIMEOUT = 2'd3
    } status_t;

    typedef struct packed {
        logic [INTERVAL_W-1:0] interval_us;
        logic [COUNT_W-1:0]    rise_to_us;
        logic [COUNT_W-1:0]    echo_to_us;
        logic [15:0]           near_mm;
    } cfg_t;

    typedef struct packed {
        logic               trigger_level;
        status_t            status;
        logic [DIST_W-1:0]  range_mm;
        logic [COUNT_W-1:0] echo_width_us;
        logic               sample_valid;
        logic               obstacle_near;
        logic               sample_updated;
    } result_t;

    function automatic logic [DIST_W-1:0] dist_from_width(input logic [COUNT_W-1:0] width);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(width) * PROD_W'(DIST_MULT);
        return prod[DIST_SHIFT +: DIST_W];
    endfunction

endpackage

[rtl/core/ultrasonic_range_sequencer.sv]
// Top level of the ultrasonic range sequencer: input stage, sequencer, result register.
// Depends on ursq_pkg, ursq_cfg and ursq_seq.
// A tick item is held in the input stage, and its result item in the result register.
// Throughput: one item per cycle unless the output stalls; each tick needs only one phase-logic pass.
// The input stage accepts a new item while a finished result waits on a stalled output.
// Reset (asynchronous, active low) empties both stages, loads the register reset values
// and puts the sequencer idle with all counters and the last sample cleared.
module ultrasonic_range_sequencer
    import ursq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Tick items: one sampled echo level per microsecond.
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   echo_level,

    // Result items: one per tick.
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   trigger_level,
    output logic [1:0]             status,
    output logic [DIST_W-1:0]      range_mm,
    output logic [COUNT_W-1:0]     echo_width_us,
    output logic                   sample_valid,
    output logic                   obstacle_near,
    output logic                   sample_updated,

    // Register writes.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic    inp_valid_reg;
    logic    echo_reg;
    logic    out_valid_reg;
    result_t result_reg;
    result_t seq_res;
    cfg_t    cfg;
    logic    advance;

    // Register writes are always taken and not checked; the user issues them only while the block is idle.
    assign cfg_ready = 1'b1;

    ursq_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The held tick moves on when the result register is empty or being emptied
    // this cycle. The input stage only pushes back when it is full and cannot move.
    assign advance  = inp_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = inp_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inp_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            inp_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            inp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            echo_reg <= echo_level;
        end
    end

    // The sequencer steps its state exactly once for each tick that moves on.
    ursq_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .echo  (echo_reg),
        .cfg   (cfg),
        .res   (seq_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= seq_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign trigger_level  = result_reg.trigger_level;
    assign status         = result_reg.status;
    assign range_mm       = result_reg.range_mm;
    assign echo_width_us  = result_reg.echo_width_us;
    assign sample_valid   = result_reg.sample_valid;
    assign obstacle_near  = result_reg.obstacle_near;
    assign sample_updated = result_reg.sample_updated;

    // The input stage only pushes back behind a full, stalled result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && out_stall)
        else $error("input stalled while the result register could take the item");

    // A tick that moves on always shows up as a result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced tick produced no result");

    // A result that was taken with nothing behind it leaves the output empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_stall && !inp_valid_reg |=> !out_valid_reg)
        else $error("result repeated after it was taken");

endmodule

[rtl/core/ursq_cfg.sv]
// Configuration register file of the ultrasonic range sequencer.
// Depends on ursq_pkg for register codes, widths and reset values.
module ursq_cfg
    import ursq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interval_us <= INTERVAL_RST;
            cfg_reg.rise_to_us  <= RISE_TO_RST;
            cfg_reg.echo_to_us  <= ECHO_TO_RST;
            cfg_reg.near_mm     <= NEAR_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_INTERVAL: cfg_reg.interval_us <= wr_data;
                CFG_RISE_TO:  cfg_reg.rise_to_us  <= wr_data[COUNT_W-1:0];
                CFG_ECHO_TO:  cfg_reg.echo_to_us  <= wr_data[COUNT_W-1:0];
                CFG_NEAR:     cfg_reg.near_mm     <= wr_data[15:0];
                default:      cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/ursq_seq.sv]
// Trigger/echo sequencer: phase machine, counters and the last-sample state.
// Depends on ursq_pkg; advances by one tick whenever step is high.
module ursq_seq
    import ursq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  logic    echo,
    input  cfg_t    cfg,
    output result_t res
);

    phase_t                phase_reg, phase_next;
    logic [COUNT_W-1:0]    phase_count_reg, phase_count_next;
    logic [INTERVAL_W-1:0] interval_count_reg, interval_count_next;
    logic [DIST_W-1:0]     last_distance_reg, last_distance_next;
    logic [COUNT_W-1:0]    last_width_reg, last_width_next;
    status_t               last_status_reg, last_status_next;
    logic                  last_valid_reg, last_valid_next;

    logic [INTERVAL_W-1:0] cnt;
    logic [COUNT_W:0]      n;
    logic                  start;
    logic                  trig;
    logic                  updated;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            phase_count_reg    <= '0;
            interval_count_reg <= '0;
            last_distance_reg  <= '0;
            last_width_reg     <= '0;
            last_status_reg    <= ST_IDLE;
            last_valid_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            phase_count_reg    <= phase_count_next;
            interval_count_reg <= interval_count_next;
            last_distance_reg  <= last_distance_next;
            last_width_reg     <= last_width_next;
            last_status_reg    <= last_status_next;
            last_valid_reg     <= last_valid_next;
        end
    end

    always_comb
    begin
        cnt   = (interval_count_reg == INTERVAL_MAX) ? interval_count_reg
                                                     : interval_count_reg + 1'b1;
        n     = {1'b0, phase_count_reg} + 1'b1;
        start = (phase_reg == PH_IDLE) && (cnt >= cfg.interval_us);

        phase_next          = phase_reg;
        phase_count_next    = phase_count_reg;
        interval_count_next = cnt;
        last_distance_next  = last_distance_reg;
        last_width_next     = last_width_reg;
        last_status_next    = last_status_reg;
        last_valid_next     = last_valid_reg;
        trig                = 1'b0;
        updated             = 1'b0;

        if (start)
        begin
            interval_count_next = '0;
            phase_next          = PH_TRIG_LOW;
            phase_count_next    = 16'd1;
            last_status_next    = ST_WAIT;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_TRIG_LOW:
                begin
                    if (n >= LOW_TICKS)
                    begin
                        phase_next       = PH_TRIG_HIGH;
                        phase_count_next = '0;
                    end
                    else
                    begin
                        phase_count_next = n[COUNT_W-1:0];
                    end
                end
                PH_TRIG_HIGH:
                begin
                    trig = 1'b1;
                    if (n >= HIGH_TICKS)
                    begin
                        phase_next       = PH_WAIT_RISE;
                        phase_count_next = '0;
                    end
                    else
                    begin
                        phase_count_next = n[COUNT_W-1:0];
                    end
                end
                PH_WAIT_RISE:
                begin
                    // An echo timeout of 0 or 1 ends the measurement on the rising tick.
                    if (echo)
                    begin
                        if (cfg.echo_to_us <= 16'd1)
                        begin
                            phase_next       = PH_IDLE;
                            phase_count_next = '0;
                            last_status_next = ST_TIMEOUT;
                            last_valid_next  = 1'b0;
                            updated          = 1'b1;
                        end
                        else
                        begin
                            phase_next       = PH_MEASURE;
                            phase_count_next = 16'd1;
                        end
                    end
                    else if (n >= {1'b0, cfg.rise_to_us})
                    begin
                        phase_next       = PH_IDLE;
                        phase_count_next = '0;
                        last_status_next = ST_TIMEOUT;
                        last_valid_next  = 1'b0;
                        updated          = 1'b1;
                    end
                    else
                    begin
                        phase_count_next = n[COUNT_W-1:0];
                    end
                end
                PH_MEASURE:
                begin
                    if (!echo)
                    begin
                        last_width_next    = phase_count_reg;
                        last_distance_next = dist_from_width(phase_count_reg);
                        last_status_next   = ST_READY;
                        last_valid_next    = 1'b1;
                        phase_next         = PH_IDLE;
                        phase_count_next   = '0;
                        updated            = 1'b1;
                    end
                    else if (n >= {1'b0, cfg.echo_to_us})
                    begin
                        phase_next       = PH_IDLE;
                        phase_count_next = '0;
                        last_status_next = ST_TIMEOUT;
                        last_valid_next  = 1'b0;
                        updated          = 1'b1;
                    end
                    else
                    begin
                        phase_count_next = n[COUNT_W-1:0];
                    end
                end
                default:
                begin
                    phase_next       = PH_IDLE;
                    phase_count_next = '0;
                end
            endcase
        end

        res.trigger_level  = trig;
        res.status         = last_status_next;
        res.range_mm       = last_distance_next;
        res.echo_width_us  = last_width_next;
        res.sample_valid   = last_valid_next;
        res.obstacle_near  = last_valid_next &&
                             ({2'b00, last_distance_next} <= cfg.near_mm);
        res.sample_updated = updated;
    end

    // The trigger pin is only driven high from the high-pulse phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && res.trigger_level |-> phase_reg == PH_TRIG_HIGH)
        else $error("trigger high outside the high-pulse phase");

    // A concluded measurement always leaves the sequencer idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && res.sample_updated |=> phase_reg == PH_IDLE && phase_count_reg == '0)
        else $error("sequencer not idle after a measurement concluded");

    // A concluded measurement reports either ready with a valid sample or a timeout.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && res.sample_updated |->
            (res.status == ST_READY && res.sample_valid) ||
            (res.status == ST_TIMEOUT && !res.sample_valid))
        else $error("concluded measurement with inconsistent status");

    // A start clears the interval counter for the next tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && start |=> interval_count_reg == '0 && phase_reg == PH_TRIG_LOW)
        else $error("start did not restart the interval");

endmodule
